### hdl/ple_pkg.sv
// Shared types, widths and codes of the piecewise linear envelope generator.
package ple_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_POINTS_DEF    = 16;
    localparam int DURATION_BITS_DEF = 16;

    // Fixed field widths
    localparam int LEVEL_W   = 16;
    localparam int POS_W     = 20;
    localparam int STEP_W    = 16;
    localparam int COUNT_W   = 5;
    localparam int INDEX_W   = 4;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Divider dividend: the advanced position (one carry bit) or the low product bits
    localparam int DVD_W     = (POS_W + 1 > LEVEL_W) ? POS_W + 1 : LEVEL_W;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_STEP    = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_WRITE   = 2'd2,
        CMD_RESTART = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT = 2'd0,
        REG_ONE_SHOT    = 2'd1,
        REG_STEP_SIZE   = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

    // Divider request from the sequencer
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

endpackage

### hdl/ple_table.sv
// Breakpoint table: level and duration memories, duration valid bits.
module ple_table #(
    parameter int MAX_POINTS    = ple_pkg::MAX_POINTS_DEF,
    parameter int DURATION_BITS = ple_pkg::DURATION_BITS_DEF,
    parameter int IDX_W         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [ple_pkg::LEVEL_W-1:0] wr_level,
    input  logic [DURATION_BITS-1:0]    wr_dur,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [ple_pkg::LEVEL_W-1:0] rd_level,
    output logic [DURATION_BITS-1:0]    rd_dur
);

    logic [ple_pkg::LEVEL_W-1:0] mem_level [MAX_POINTS];
    logic [DURATION_BITS-1:0]    mem_dur   [MAX_POINTS];
    logic [MAX_POINTS-1:0]       valid_reg;
    logic                        rd_valid_reg;
    logic [ple_pkg::LEVEL_W-1:0] rd_level_reg;
    logic [DURATION_BITS-1:0]    rd_dur_reg;

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_level[wr_addr] <= wr_level;
            mem_dur[wr_addr]   <= wr_dur;
        end
        rd_level_reg <= mem_level[rd_addr];
        rd_dur_reg   <= mem_dur[rd_addr];
    end

    // Duration valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // An unwritten duration reads as zero
    assign rd_level = rd_level_reg;
    assign rd_dur   = rd_valid_reg ? rd_dur_reg : '0;

endmodule

### hdl/ple_div.sv
// Shared restoring divider, one quotient bit per cycle.
module ple_div #(
    parameter int TOT_W = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ple_pkg::div_req_t           req,
    input  logic [ple_pkg::DVD_W-1:0]   dividend,
    input  logic [TOT_W-1:0]            divisor,
    input  logic [TOT_W-1:0]            rem_init,
    output logic                        done,
    output logic [ple_pkg::LEVEL_W-1:0] quotient,
    output logic [TOT_W-1:0]            remainder
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [ple_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [ple_pkg::DVD_W-1:0]       dvd_reg;
    logic [TOT_W-1:0]                rem_reg;
    logic [TOT_W-1:0]                dsr_reg;
    logic [ple_pkg::LEVEL_W-1:0]     quo_reg;
    logic [TOT_W:0]                  shifted;
    logic [TOT_W:0]                  trial;
    logic                            ge;
    logic [TOT_W-1:0]                rem_step;

    // One shift and trial subtract
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[ple_pkg::DVD_W-1]};
        trial    = shifted - {1'b0, dsr_reg};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_step = ge ? trial[TOT_W-1:0] : shifted[TOT_W-1:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ple_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= dividend;
            rem_reg <= rem_init;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ple_pkg::DVD_W-2:0], 1'b0};
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[ple_pkg::LEVEL_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hdl/piecewise_linear_envelope_top.sv
// Piecewise linear breakpoint envelope generator, top level and sequencer.
//
// Each item is one command: step (evaluate the frame position, then advance it by
// step_size modulo the loop total, or in one-shot mode hold it before the closing
// segment), query (evaluate any position), write a breakpoint, or restart. The
// block takes one item at a time. An evaluation scans the table one entry per
// cycle through the memory read port, then, for an item that hits a segment, runs
// a multiply and a 16 bit restoring divide for the interpolation. In loop mode a
// step then runs the same divider again over 21 bits to reduce the position
// modulo the total. The result waits in an output register, and the next item is
// accepted while it does. No clearing pass is needed after reset: unwritten
// durations read as zero through valid bits.
module piecewise_linear_envelope_top #(
    parameter int MAX_POINTS    = ple_pkg::MAX_POINTS_DEF,
    parameter int DURATION_BITS = ple_pkg::DURATION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration
    input  logic                          cfg_we,
    input  logic [ple_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ple_pkg::CFG_DAT_W-1:0] cfg_data,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ple_pkg::CMD_W-1:0]     cmd,
    input  logic [ple_pkg::POS_W-1:0]     query_position,
    input  logic [ple_pkg::INDEX_W-1:0]   point_index,
    input  logic [ple_pkg::LEVEL_W-1:0]   point_level,
    input  logic [15:0]                   point_duration,
    // Output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ple_pkg::LEVEL_W-1:0]   level,
    output logic [ple_pkg::POS_W-1:0]     position_used,
    output logic                          in_range,
    output logic                          held
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int TOT_W = DURATION_BITS + $clog2(MAX_POINTS);
    localparam int MUL_W = ple_pkg::LEVEL_W + DURATION_BITS;
    localparam int CMP_W = (TOT_W + 1 > ple_pkg::POS_W) ? TOT_W + 1 : ple_pkg::POS_W;
    localparam int ADV_W = (TOT_W > ple_pkg::POS_W + 1) ? TOT_W : ple_pkg::POS_W + 1;
    localparam int LW    = ple_pkg::LEVEL_W;
    localparam int PW    = ple_pkg::POS_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DGO   = 7'b0001000,
        S_DWAIT = 7'b0010000,
        S_ADV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    // Control registers
    state_t                       state_reg, state_next;
    logic                         out_valid_reg, out_valid_next;
    logic [PW-1:0]                frame_reg, frame_next;
    logic [CNT_W-1:0]             issue_reg, issue_next;
    logic [CNT_W-1:0]             proc_reg, proc_next;
    logic                         rv_reg, rv_next;
    logic                         found_reg, found_next;
    logic                         mod_phase_reg, mod_phase_next;
    logic [ple_pkg::COUNT_W-1:0]  point_count_reg;
    logic                         one_shot_reg;
    logic [ple_pkg::STEP_W-1:0]   step_size_reg;

    // Item registers
    ple_pkg::cmd_t                cmd_reg, cmd_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [TOT_W-1:0]             start_reg, start_next;
    logic [IDX_W-1:0]             seg_reg, seg_next;
    logic [DURATION_BITS-1:0]     off_reg, off_next;
    logic [DURATION_BITS-1:0]     dur_sel_reg, dur_sel_next;
    logic [DURATION_BITS-1:0]     dur_last_reg, dur_last_next;
    logic [LW-1:0]                p0_reg, p0_next;
    logic [LW-1:0]                p1_reg, p1_next;
    logic [LW-1:0]                lvl0_reg, lvl0_next;
    logic                         up_reg, up_next;
    logic [MUL_W-1:0]             num_reg, num_next;
    logic [LW-1:0]                level_reg, level_next;
    logic                         held_reg, held_next;
    logic [LW-1:0]                out_level_reg, out_level_next;
    logic [PW-1:0]                out_pos_reg, out_pos_next;
    logic                         out_range_reg, out_range_next;
    logic                         out_held_reg, out_held_next;

    // Combinational helpers
    logic [CNT_W-1:0]             n_eff;
    logic [CNT_W-1:0]             n_m1;
    logic                         accept;
    logic                         tbl_wr_en;
    logic [IDX_W-1:0]             tbl_rd_addr;
    logic [LW-1:0]                tbl_rd_level;
    logic [DURATION_BITS-1:0]     tbl_rd_dur;
    logic [CMP_W-1:0]             pos_c, st_c, end_c;
    logic                         hit;
    logic [LW-1:0]                p1_sel;
    logic [LW-1:0]                diff;
    logic [ple_pkg::DVD_W-1:0]    next_pos;
    logic [ADV_W-1:0]             lim;
    ple_pkg::div_req_t            div_req;
    logic [ple_pkg::DVD_W-1:0]    div_dividend;
    logic [TOT_W-1:0]             div_divisor;
    logic [TOT_W-1:0]             div_rem_init;
    logic                         div_done;
    logic [LW-1:0]                div_quo;
    logic [TOT_W-1:0]             div_rem;

    // Effective point count: zero acts as one, clipped to the table size
    always_comb
    begin
        if (point_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(point_count_reg) > MAX_POINTS)
        begin
            n_eff = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = CNT_W'(point_count_reg);
        end
        n_m1 = n_eff - 1'b1;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign tbl_wr_en = accept && (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_WRITE)
                       && (32'(point_index) < MAX_POINTS);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= ple_pkg::COUNT_W'(1);
            one_shot_reg    <= 1'b0;
            step_size_reg   <= ple_pkg::STEP_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (ple_pkg::cfg_reg_t'(cfg_index))
                ple_pkg::REG_POINT_COUNT: point_count_reg <= cfg_data[ple_pkg::COUNT_W-1:0];
                ple_pkg::REG_ONE_SHOT:    one_shot_reg    <= cfg_data[0];
                ple_pkg::REG_STEP_SIZE:   step_size_reg   <= cfg_data[ple_pkg::STEP_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Breakpoint table
    ple_table #(
        .MAX_POINTS    (MAX_POINTS),
        .DURATION_BITS (DURATION_BITS),
        .IDX_W         (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr_en),
        .wr_addr  (IDX_W'(point_index)),
        .wr_level (point_level),
        .wr_dur   (DURATION_BITS'(point_duration)),
        .rd_addr  (tbl_rd_addr),
        .rd_level (tbl_rd_level),
        .rd_dur   (tbl_rd_dur)
    );

    // Segment match against the running start
    always_comb
    begin
        pos_c = CMP_W'(pos_reg);
        st_c  = CMP_W'(start_reg);
        end_c = st_c + CMP_W'(tbl_rd_dur);
        hit   = !found_reg && (tbl_rd_dur != '0) && (pos_c >= st_c) && (pos_c < end_c);
    end

    // Closing segment ramps back to the first level
    assign p1_sel   = (CNT_W'(seg_reg) == n_m1) ? lvl0_reg : p1_reg;
    assign diff     = (p1_sel >= p0_reg) ? (p1_sel - p0_reg) : (p0_reg - p1_sel);
    assign next_pos = ple_pkg::DVD_W'(pos_reg) + ple_pkg::DVD_W'(step_size_reg);
    assign lim      = ADV_W'(start_reg) - ADV_W'(dur_last_reg);

    // Divider operands: interpolation quotient, or position modulo the total
    always_comb
    begin
        div_req.start = (state_reg == S_DGO);
        if (mod_phase_reg)
        begin
            div_req.steps = ple_pkg::DIV_CNT_W'(ple_pkg::DVD_W);
            div_dividend  = next_pos;
            div_divisor   = start_reg;
            div_rem_init  = '0;
        end
        else
        begin
            div_req.steps = ple_pkg::DIV_CNT_W'(LW);
            div_dividend  = {num_reg[LW-1:0], {(ple_pkg::DVD_W - LW){1'b0}}};
            div_divisor   = TOT_W'(dur_sel_reg);
            div_rem_init  = TOT_W'(num_reg[MUL_W-1:LW]);
        end
    end

    ple_div #(
        .TOT_W (TOT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .rem_init  (div_rem_init),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        frame_next     = frame_reg;
        issue_next     = issue_reg;
        proc_next      = proc_reg;
        rv_next        = 1'b0;
        found_next     = found_reg;
        mod_phase_next = mod_phase_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        seg_next       = seg_reg;
        off_next       = off_reg;
        dur_sel_next   = dur_sel_reg;
        dur_last_next  = dur_last_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        lvl0_next      = lvl0_reg;
        up_next        = up_reg;
        num_next       = num_reg;
        level_next     = level_reg;
        held_next      = held_reg;
        out_level_next = out_level_reg;
        out_pos_next   = out_pos_reg;
        out_range_next = out_range_reg;
        out_held_next  = out_held_reg;
        tbl_rd_addr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = ple_pkg::cmd_t'(cmd);
                    issue_next     = '0;
                    proc_next      = '0;
                    found_next     = 1'b0;
                    mod_phase_next = 1'b0;
                    start_next     = '0;
                    level_next     = '0;
                    held_next      = 1'b0;
                    unique case (ple_pkg::cmd_t'(cmd))
                        ple_pkg::CMD_STEP:
                        begin
                            pos_next   = frame_reg;
                            state_next = S_SCAN;
                        end
                        ple_pkg::CMD_QUERY:
                        begin
                            pos_next   = query_position;
                            state_next = S_SCAN;
                        end
                        ple_pkg::CMD_WRITE:
                        begin
                            pos_next   = '0;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            frame_next = '0;
                            pos_next   = '0;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle, process its data in the cycle after
                if (issue_reg < n_eff)
                begin
                    tbl_rd_addr = issue_reg[IDX_W-1:0];
                    issue_next  = issue_reg + 1'b1;
                    rv_next     = 1'b1;
                end
                if (rv_reg)
                begin
                    if (proc_reg == '0)
                    begin
                        lvl0_next = tbl_rd_level;
                    end
                    if (found_reg && (proc_reg == CNT_W'(seg_reg) + 1'b1))
                    begin
                        p1_next = tbl_rd_level;
                    end
                    if (hit)
                    begin
                        found_next   = 1'b1;
                        seg_next     = proc_reg[IDX_W-1:0];
                        p0_next      = tbl_rd_level;
                        off_next     = DURATION_BITS'(pos_c - st_c);
                        dur_sel_next = tbl_rd_dur;
                    end
                    if (proc_reg == n_m1)
                    begin
                        dur_last_next = tbl_rd_dur;
                        if (found_next)
                        begin
                            state_next = S_MUL;
                        end
                        else if (cmd_reg == ple_pkg::CMD_STEP)
                        begin
                            state_next = S_ADV;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    start_next = start_reg + TOT_W'(tbl_rd_dur);
                    proc_next  = proc_reg + 1'b1;
                end
            end

            S_MUL:
            begin
                up_next    = (p1_sel >= p0_reg);
                num_next   = MUL_W'(diff) * MUL_W'(off_reg);
                state_next = S_DGO;
            end

            S_DGO:
            begin
                state_next = S_DWAIT;
            end

            S_DWAIT:
            begin
                if (div_done)
                begin
                    if (!mod_phase_reg)
                    begin
                        // Rising ramp floors, falling ramp rounds the drop up
                        if (up_reg)
                        begin
                            level_next = p0_reg + div_quo;
                        end
                        else
                        begin
                            level_next = p0_reg - div_quo - LW'(div_rem != '0);
                        end
                        state_next = (cmd_reg == ple_pkg::CMD_STEP) ? S_ADV : S_OUT;
                    end
                    else
                    begin
                        frame_next = PW'(div_rem);
                        state_next = S_OUT;
                    end
                end
            end

            S_ADV:
            begin
                if (one_shot_reg)
                begin
                    // Hold once the closing segment would be entered
                    if (ADV_W'(next_pos) < lim)
                    begin
                        frame_next = PW'(next_pos);
                    end
                    else
                    begin
                        held_next = 1'b1;
                    end
                    state_next = S_OUT;
                end
                else if (start_reg == '0)
                begin
                    frame_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    mod_phase_next = 1'b1;
                    state_next     = S_DGO;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_level_next = level_reg;
                    out_pos_next   = pos_reg;
                    out_range_next = found_reg;
                    out_held_next  = held_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            frame_reg     <= '0;
            issue_reg     <= '0;
            proc_reg      <= '0;
            rv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            mod_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            frame_reg     <= frame_next;
            issue_reg     <= issue_next;
            proc_reg      <= proc_next;
            rv_reg        <= rv_next;
            found_reg     <= found_next;
            mod_phase_reg <= mod_phase_next;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pos_reg       <= pos_next;
        start_reg     <= start_next;
        seg_reg       <= seg_next;
        off_reg       <= off_next;
        dur_sel_reg   <= dur_sel_next;
        dur_last_reg  <= dur_last_next;
        p0_reg        <= p0_next;
        p1_reg        <= p1_next;
        lvl0_reg      <= lvl0_next;
        up_reg        <= up_next;
        num_reg       <= num_next;
        level_reg     <= level_next;
        held_reg      <= held_next;
        out_level_reg <= out_level_next;
        out_pos_reg   <= out_pos_next;
        out_range_reg <= out_range_next;
        out_held_reg  <= out_held_next;
    end

    assign out_valid     = out_valid_reg;
    assign level         = out_level_reg;
    assign position_used = out_pos_reg;
    assign in_range      = out_range_reg;
    assign held          = out_held_reg;

    // Checks
    a_offset_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (off_reg < dur_sel_reg))
        else $error("segment offset not below its duration");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DWAIT))
        else $error("divider finished while sequencer not waiting");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output state");

    a_idle_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && (!out_valid_reg || out_ready)) |=> in_ready)
        else $error("sequencer not idle after loading a result");

endmodule
